/* sv/sha1_message_digest_macros.svh */
// Assertion macros shared by the digest block.
`ifndef SHA1_MESSAGE_DIGEST_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SHA1MD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define SHA1MD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/sha1md_pkg.sv */
package sha1md_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned BLOCK_WORDS  = 16;
  localparam int unsigned CHAIN_WORDS  = 5;
  localparam int unsigned COUNT_W      = 61;
  localparam int unsigned ROUNDS       = 80;
  localparam int unsigned DIGEST_BYTES = 20;

  localparam logic [3:0] LEN_HI_WORD = 4'd14;
  localparam logic [3:0] LEN_LO_WORD = 4'd15;

  localparam logic [WORD_W-1:0] H_INIT [CHAIN_WORDS] = '{
    32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
  };

  localparam logic [WORD_W-1:0] K_R0 = 32'h5A82_7999;
  localparam logic [WORD_W-1:0] K_R1 = 32'h6ED9_EBA1;
  localparam logic [WORD_W-1:0] K_R2 = 32'h8F1B_BCDC;
  localparam logic [WORD_W-1:0] K_R3 = 32'hCA62_C1D6;

  localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h80;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLOAD,
    S_COMP,
    S_FIN,
    S_PAD,
    S_FILL,
    S_LEN_HI,
    S_LEN_LO,
    S_OUT
  } state_e;

  // What follows a compression.
  typedef enum logic [1:0] {
    NX_IDLE,
    NX_PAD,
    NX_FILL,
    NX_OUT
  } after_e;

  // Place a byte in its big-endian lane of a word.
  function automatic logic [WORD_W-1:0] byte_lane(input logic [BYTE_W-1:0] b,
                                                  input logic [1:0] lane);
    logic [WORD_W-1:0] r;
    begin
      case (lane)
        2'd0:    r = {b, 24'h0};
        2'd1:    r = {8'h0, b, 16'h0};
        2'd2:    r = {16'h0, b, 8'h0};
        default: r = {24'h0, b};
      endcase
      return r;
    end
  endfunction

endpackage

/* sv/sha1md_msg_if.sv */
interface sha1md_msg_if;
  logic                           valid;
  logic                           ready;
  logic [sha1md_pkg::BYTE_W-1:0]  msg_byte;
  logic                           byte_valid;
  logic                           end_of_message;

  modport source (output valid, output msg_byte, output byte_valid,
                  output end_of_message, input ready);
  modport sink   (input valid, input msg_byte, input byte_valid,
                  input end_of_message, output ready);
endinterface

/* sv/sha1md_dgst_if.sv */
interface sha1md_dgst_if;
  logic                           valid;
  logic                           ready;
  logic [sha1md_pkg::BYTE_W-1:0]  digest_byte;
  logic                           digest_last;

  modport source (output valid, output digest_byte, output digest_last, input ready);
  modport sink   (input valid, input digest_byte, input digest_last, output ready);
endinterface

/* sv/sha1md_ram.sv */
module sha1md_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry and read one entry; the read data is registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/sha1_message_digest.sv */
// A byte item that does not fill a block is taken in the idle state with no other work.
// A byte that fills a block starts a compression: chain load, 80 rounds, chain update.
// A closing item adds pad, zero and length writes, one or two compressions
// and 20 digest items, one per cycle when the sink is ready.
// Compression runs one round per cycle, fed by the block buffer memory.
// Reset clears the byte count and loads the initial chaining values; no sweep.
`include "sha1_message_digest_macros.svh"

module sha1_message_digest (
  input  logic                clk_i,
  input  logic                rst_ni,
  sha1md_msg_if.sink          msg_i,
  sha1md_dgst_if.source       dgst_o
);

  localparam int unsigned AW = $clog2(sha1md_pkg::BLOCK_WORDS);
  localparam int unsigned WW = sha1md_pkg::WORD_W;

  sha1md_pkg::state_e state_q, state_d;
  sha1md_pkg::after_e after_q, after_d;

  logic [sha1md_pkg::COUNT_W-1:0] count_q, count_d;
  logic [WW-1:0]                  acc_q, acc_d;
  logic [6:0]                     rnd_q, rnd_d;
  logic [4:0]                     fill_q, fill_d;
  logic                           len_blk_q, len_blk_d;
  logic [4:0]                     out_idx_q, out_idx_d;
  logic [WW-1:0]                  chain_q [sha1md_pkg::CHAIN_WORDS];
  logic [WW-1:0]                  chain_d [sha1md_pkg::CHAIN_WORDS];
  logic [WW-1:0]                  work_q  [sha1md_pkg::CHAIN_WORDS];
  logic [WW-1:0]                  work_d  [sha1md_pkg::CHAIN_WORDS];
  logic [WW-1:0]                  w_q     [sha1md_pkg::BLOCK_WORDS];
  logic [WW-1:0]                  w_d     [sha1md_pkg::BLOCK_WORDS];

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata;

  logic [WW-1:0] w_cur;
  logic [WW-1:0] f_val;
  logic [WW-1:0] k_val;
  logic [WW-1:0] t_val;
  logic [WW-1:0] dig_word;
  logic [1:0]    lane;
  logic [4:0]    fill_lim;

  localparam logic [4:0] LAST_IDX  = 5'(sha1md_pkg::DIGEST_BYTES - 1);
  localparam logic [6:0] LAST_RND  = 7'(sha1md_pkg::ROUNDS - 1);
  localparam logic [4:0] FILL_FULL = 5'(sha1md_pkg::BLOCK_WORDS);
  localparam logic [4:0] FILL_LEN  = 5'(sha1md_pkg::LEN_HI_WORD);

  sha1md_ram #(
    .WIDTH (WW),
    .DEPTH (sha1md_pkg::BLOCK_WORDS)
  ) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign lane     = count_q[1:0];
  assign fill_lim = len_blk_q ? FILL_LEN : FILL_FULL;

  // Expand the schedule: first sixteen words from memory, then from the window.
  always_comb begin
    if (rnd_q < 7'(sha1md_pkg::BLOCK_WORDS)) begin
      w_cur = ram_rdata;
    end else begin
      w_cur = {(w_q[13][30:0] ^ w_q[8][30:0] ^ w_q[2][30:0] ^ w_q[0][30:0]),
               (w_q[13][31] ^ w_q[8][31] ^ w_q[2][31] ^ w_q[0][31])};
    end
  end

  // Select round function and constant.
  always_comb begin
    if (rnd_q < 7'd20) begin
      f_val = (work_q[1] & work_q[2]) | (~work_q[1] & work_q[3]);
      k_val = sha1md_pkg::K_R0;
    end else if (rnd_q < 7'd40) begin
      f_val = work_q[1] ^ work_q[2] ^ work_q[3];
      k_val = sha1md_pkg::K_R1;
    end else if (rnd_q < 7'd60) begin
      f_val = (work_q[1] & work_q[2]) | (work_q[1] & work_q[3]) | (work_q[2] & work_q[3]);
      k_val = sha1md_pkg::K_R2;
    end else begin
      f_val = work_q[1] ^ work_q[2] ^ work_q[3];
      k_val = sha1md_pkg::K_R3;
    end
    t_val = {work_q[0][26:0], work_q[0][31:27]} + f_val + work_q[4] + k_val + w_cur;
  end

  // Next state, memory access and datapath updates.
  always_comb begin
    state_d   = state_q;
    after_d   = after_q;
    count_d   = count_q;
    acc_d     = acc_q;
    rnd_d     = rnd_q;
    fill_d    = fill_q;
    len_blk_d = len_blk_q;
    out_idx_d = out_idx_q;
    chain_d   = chain_q;
    work_d    = work_q;
    w_d       = w_q;
    ram_we    = 1'b0;
    ram_waddr = count_q[5:2];
    ram_wdata = acc_q;
    ram_raddr = '0;

    unique case (state_q)
      sha1md_pkg::S_IDLE: begin
        if (msg_i.valid) begin
          if (msg_i.byte_valid) begin
            // Pack the byte; a word's first byte overwrites the whole word.
            if (lane == 2'd0) begin
              acc_d = sha1md_pkg::byte_lane(msg_i.msg_byte, lane);
            end else begin
              acc_d = acc_q | sha1md_pkg::byte_lane(msg_i.msg_byte, lane);
            end
            count_d   = count_q + 61'd1;
            ram_we    = (lane == 2'd3);
            ram_wdata = acc_d;
            if (count_q[5:0] == 6'd63) begin
              state_d = sha1md_pkg::S_CLOAD;
              after_d = msg_i.end_of_message ? sha1md_pkg::NX_PAD : sha1md_pkg::NX_IDLE;
            end else if (msg_i.end_of_message) begin
              state_d = sha1md_pkg::S_PAD;
            end
          end else if (msg_i.end_of_message) begin
            state_d = sha1md_pkg::S_PAD;
          end
        end
      end

      sha1md_pkg::S_PAD: begin
        // Write the word that carries the pad byte.
        ram_we = 1'b1;
        if (lane == 2'd0) begin
          ram_wdata = sha1md_pkg::byte_lane(sha1md_pkg::PAD_BYTE, lane);
        end else begin
          ram_wdata = acc_q | sha1md_pkg::byte_lane(sha1md_pkg::PAD_BYTE, lane);
        end
        fill_d    = {1'b0, count_q[5:2]} + 5'd1;
        len_blk_d = (count_q[5:2] < sha1md_pkg::LEN_HI_WORD);
        state_d   = sha1md_pkg::S_FILL;
      end

      sha1md_pkg::S_FILL: begin
        // Zero the rest of the block, or of the words before the length.
        if (fill_q < fill_lim) begin
          ram_we    = 1'b1;
          ram_waddr = fill_q[AW-1:0];
          ram_wdata = '0;
          fill_d    = fill_q + 5'd1;
        end else if (len_blk_q) begin
          state_d = sha1md_pkg::S_LEN_HI;
        end else begin
          state_d = sha1md_pkg::S_CLOAD;
          after_d = sha1md_pkg::NX_FILL;
        end
      end

      sha1md_pkg::S_LEN_HI: begin
        ram_we    = 1'b1;
        ram_waddr = sha1md_pkg::LEN_HI_WORD;
        ram_wdata = count_q[60:29];
        state_d   = sha1md_pkg::S_LEN_LO;
      end

      sha1md_pkg::S_LEN_LO: begin
        ram_we    = 1'b1;
        ram_waddr = sha1md_pkg::LEN_LO_WORD;
        ram_wdata = {count_q[28:0], 3'b000};
        state_d   = sha1md_pkg::S_CLOAD;
        after_d   = sha1md_pkg::NX_OUT;
      end

      sha1md_pkg::S_CLOAD: begin
        // Load working words and fetch the first schedule word.
        work_d  = chain_q;
        rnd_d   = '0;
        state_d = sha1md_pkg::S_COMP;
      end

      sha1md_pkg::S_COMP: begin
        ram_raddr = rnd_q[AW-1:0] + 4'd1;
        work_d[4] = work_q[3];
        work_d[3] = work_q[2];
        work_d[2] = {work_q[1][1:0], work_q[1][31:2]};
        work_d[1] = work_q[0];
        work_d[0] = t_val;
        for (int i = 0; i < sha1md_pkg::BLOCK_WORDS - 1; i++) begin
          w_d[i] = w_q[i+1];
        end
        w_d[sha1md_pkg::BLOCK_WORDS-1] = w_cur;
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == LAST_RND) begin
          state_d = sha1md_pkg::S_FIN;
        end
      end

      sha1md_pkg::S_FIN: begin
        // Fold the working words into the chain.
        for (int i = 0; i < sha1md_pkg::CHAIN_WORDS; i++) begin
          chain_d[i] = chain_q[i] + work_q[i];
        end
        unique case (after_q)
          sha1md_pkg::NX_IDLE: state_d = sha1md_pkg::S_IDLE;
          sha1md_pkg::NX_PAD:  state_d = sha1md_pkg::S_PAD;
          sha1md_pkg::NX_FILL: begin
            fill_d    = '0;
            len_blk_d = 1'b1;
            state_d   = sha1md_pkg::S_FILL;
          end
          default: begin
            out_idx_d = '0;
            state_d   = sha1md_pkg::S_OUT;
          end
        endcase
      end

      sha1md_pkg::S_OUT: begin
        // Emit digest items; restart the chain after the last one.
        if (dgst_o.ready) begin
          if (out_idx_q == LAST_IDX) begin
            chain_d = sha1md_pkg::H_INIT;
            count_d = '0;
            state_d = sha1md_pkg::S_IDLE;
          end else begin
            out_idx_d = out_idx_q + 5'd1;
          end
        end
      end

      default: state_d = sha1md_pkg::S_IDLE;
    endcase
  end

  // Hold control state and chaining words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sha1md_pkg::S_IDLE;
      after_q   <= sha1md_pkg::NX_IDLE;
      count_q   <= '0;
      rnd_q     <= '0;
      fill_q    <= '0;
      len_blk_q <= 1'b0;
      out_idx_q <= '0;
      chain_q   <= sha1md_pkg::H_INIT;
    end else begin
      state_q   <= state_d;
      after_q   <= after_d;
      count_q   <= count_d;
      rnd_q     <= rnd_d;
      fill_q    <= fill_d;
      len_blk_q <= len_blk_d;
      out_idx_q <= out_idx_d;
      chain_q   <= chain_d;
    end
  end

  // Hold datapath words.
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    work_q <= work_d;
    w_q    <= w_d;
  end

  // Pick the digest byte, most significant first.
  assign dig_word = chain_q[out_idx_q[4:2]];

  always_comb begin
    case (out_idx_q[1:0])
      2'd0:    dgst_o.digest_byte = dig_word[31:24];
      2'd1:    dgst_o.digest_byte = dig_word[23:16];
      2'd2:    dgst_o.digest_byte = dig_word[15:8];
      default: dgst_o.digest_byte = dig_word[7:0];
    endcase
  end

  assign dgst_o.valid       = (state_q == sha1md_pkg::S_OUT);
  assign dgst_o.digest_last = (out_idx_q == LAST_IDX);
  assign msg_i.ready        = (state_q == sha1md_pkg::S_IDLE);

  `SHA1MD_ASSERT(a_no_in_during_out, !(msg_i.ready && dgst_o.valid), "input taken while digest pending")
  `SHA1MD_ASSERT(a_no_write_in_comp, !((state_q == sha1md_pkg::S_COMP) && ram_we), "block written during compression")
  `SHA1MD_ASSERT(a_round_range, !((state_q == sha1md_pkg::S_COMP) && (rnd_q > LAST_RND)), "round counter out of range")
  `SHA1MD_ASSERT(a_fill_range, fill_q <= FILL_FULL, "fill pointer beyond block")
  `SHA1MD_ASSERT_NEXT(a_restart, dgst_o.valid && dgst_o.ready && dgst_o.digest_last, (count_q == '0) && (state_q == sha1md_pkg::S_IDLE), "no restart after digest")

endmodule
